// ===== rtl/tpl_pkg.sv =====
// shared constants, codes and helpers for the tetrahedral probe interpolator
// no dependencies; imported by the top level, the checker and the testbench
package tpl_pkg;

  localparam int MAX_TETRA_DEF  = 256;
  localparam int MAX_PROBES_DEF = 256;
  localparam int SH_COEFS       = 27;

  localparam int ACC_W = 52;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // input word kinds
  localparam logic [1:0] FUNC_LOAD_TETRA = 2'd0;
  localparam logic [1:0] FUNC_LOAD_PROBE = 2'd1;
  localparam logic [1:0] FUNC_QUERY      = 2'd2;
  localparam logic [1:0] FUNC_UNUSED     = 2'd3;

  // kinds of memory read in flight
  localparam logic [1:0] RD_REF  = 2'd0;
  localparam logic [1:0] RD_MAT  = 2'd1;
  localparam logic [1:0] RD_IDS  = 2'd2;
  localparam logic [1:0] RD_COEF = 2'd3;

  typedef logic signed [ACC_W-1:0] acc_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input acc_t v);
    logic signed [31:0] r;
    if (v > acc_t'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (v < acc_t'(-64'sh80000000)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/tpl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module tpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tetra_probe_locate_interpolate.sv =====
// tetrahedral light-probe locator and sh blender, q16.16 fixed point
// sequence: a load is written to its table when accepted; a query scans the tetrahedra in
// order, then blends each of the 27 coefficient words; output stalls hold it back
// throughput: one word at a time; the single shared 32x32 multiplier and the
// single-read-port tables set the pace. not-found queries emit 27 words back to back while out_tready stays high
// reset: synchronous active-low rst_n clears control and tetra_count; tables stay undefined
module tetra_probe_locate_interpolate
  import tpl_pkg::*;
#(
  parameter int MAX_TETRA  = MAX_TETRA_DEF,
  parameter int MAX_PROBES = MAX_PROBES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [8:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tetra_slot, tetra_word, probe_slot, coef_slot, load_value, pos_x, pos_y, pos_z
  input  logic [159:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tetra_index, weight_a, weight_b, weight_c, weight_d, coef_index, coef_value
  output logic [175:0] out_tdata,
  // found
  output logic [0:0]   out_tuser,
  output logic         out_tlast
);

  localparam int MA_W = $clog2(MAX_TETRA * 9);
  localparam int RA_W = $clog2(MAX_TETRA * 3);
  localparam int IA_W = $clog2(MAX_TETRA * 4);
  localparam int CA_W = $clog2(MAX_PROBES * SH_COEFS);
  localparam int CW   = ($clog2(MAX_TETRA + 1) > 9) ? $clog2(MAX_TETRA + 1) : 9;
  localparam int TI_W = (MAX_TETRA > 1) ? $clog2(MAX_TETRA) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_REF   = 4'd1;
  localparam logic [3:0] ST_MAT   = 4'd2;
  localparam logic [3:0] ST_MWAIT = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_IDS   = 4'd5;
  localparam logic [3:0] ST_IWAIT = 4'd6;
  localparam logic [3:0] ST_BLEND = 4'd7;
  localparam logic [3:0] ST_BWAIT = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // input fields
  logic [1:0]         f_func;
  logic [7:0]         f_tslot, f_pslot;
  logic [3:0]         f_tword;
  logic [4:0]         f_cslot;
  logic signed [31:0] f_load;
  assign f_func  = in_tuser;
  assign f_tslot = in_tdata[7:0];
  assign f_tword = in_tdata[11:8];
  assign f_pslot = in_tdata[19:12];
  assign f_cslot = in_tdata[24:20];
  assign f_load  = in_tdata[56:25];

  logic [3:0]   state_r, state_nxt;
  logic [8:0]   tcount_r;
  logic [CW-1:0] count_r, i_r, hit_r;
  logic [3:0]   cnt_r;
  logic [1:0]   mj_r, mk_r;
  logic [4:0]   ck_r;
  logic         found_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] d_r   [3];
  logic signed [31:0] t_r   [3];
  logic signed [31:0] w_r   [4];
  logic [7:0]   ids_r [4];
  logic signed [31:0] val_r;

  // read pipeline and shared multiply-accumulate
  logic         rd_v_r, rd_zero_r;
  logic [1:0]   rd_kind_r, rd_sel_r, rd_k_r;
  logic         mul_v_r, mul_first_r, mul_last_r, mul_mat_r;
  logic [1:0]   mul_k_r;
  logic signed [63:0] prod_r;
  acc_t         acc_r, acc_sum;
  logic signed [31:0] op_a, op_b;

  logic         accept;
  assign accept = in_tvalid && in_tready;

  // memories
  logic              mat_we, ref_we, ids_we, coef_we;
  logic [MA_W-1:0]   mat_wa, mat_ra;
  logic [RA_W-1:0]   ref_wa, ref_ra;
  logic [IA_W-1:0]   ids_wa, ids_ra;
  logic [CA_W-1:0]   coef_wa, coef_ra;
  logic [31:0]       mat_rd, ref_rd, coef_rd;
  logic [7:0]        ids_rd;
  logic              tslot_ok;
  logic [TI_W-1:0]   ti;
  logic [TI_W-1:0]   hi;

  assign tslot_ok = {{(CW-8){1'b0}}, f_tslot} < CW'(MAX_TETRA);
  assign ti = i_r[TI_W-1:0];
  assign hi = hit_r[TI_W-1:0];

  // load writes
  assign mat_we  = accept && f_func == FUNC_LOAD_TETRA && tslot_ok && f_tword < 4'd9;
  assign ref_we  = accept && f_func == FUNC_LOAD_TETRA && tslot_ok &&
                   f_tword >= 4'd9 && f_tword < 4'd12;
  assign ids_we  = accept && f_func == FUNC_LOAD_TETRA && tslot_ok && f_tword >= 4'd12;
  assign coef_we = accept && f_func == FUNC_LOAD_PROBE &&
                   {5'd0, f_pslot} < 13'(MAX_PROBES) && f_cslot < 5'(SH_COEFS);
  assign mat_wa  = MA_W'(f_tslot) * MA_W'(9) + MA_W'(f_tword);
  assign ref_wa  = RA_W'(f_tslot) * RA_W'(3) + RA_W'(f_tword - 4'd9);
  assign ids_wa  = IA_W'(f_tslot) * IA_W'(4) + IA_W'(f_tword[1:0]);
  assign coef_wa = CA_W'(f_pslot) * CA_W'(SH_COEFS) + CA_W'(f_cslot);

  // read addresses follow the sequencer counters
  logic [7:0] cur_id;
  logic       cur_zero;
  assign cur_id   = ids_r[cnt_r[1:0]];
  assign cur_zero = {5'd0, cur_id} >= 13'(MAX_PROBES);
  assign ref_ra  = RA_W'(ti) * RA_W'(3) + RA_W'(cnt_r[1:0]);
  assign mat_ra  = MA_W'(ti) * MA_W'(9) + MA_W'(mj_r) * MA_W'(3) + MA_W'(mk_r);
  assign ids_ra  = IA_W'(hi) * IA_W'(4) + IA_W'(cnt_r[1:0]);
  assign coef_ra = CA_W'(cur_id) * CA_W'(SH_COEFS) + CA_W'(ck_r);

  tpl_ram #(.WIDTH(32), .DEPTH(MAX_TETRA * 9)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_wa), .wdata(f_load), .raddr(mat_ra), .rdata(mat_rd));
  tpl_ram #(.WIDTH(32), .DEPTH(MAX_TETRA * 3)) u_ref (
    .clk(clk), .we(ref_we), .waddr(ref_wa), .wdata(f_load), .raddr(ref_ra), .rdata(ref_rd));
  tpl_ram #(.WIDTH(8), .DEPTH(MAX_TETRA * 4)) u_ids (
    .clk(clk), .we(ids_we), .waddr(ids_wa), .wdata(f_load[7:0]), .raddr(ids_ra),
    .rdata(ids_rd));
  tpl_ram #(.WIDTH(32), .DEPTH(MAX_PROBES * SH_COEFS)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_wa), .wdata(f_load), .raddr(coef_ra),
    .rdata(coef_rd));

  // reference-vertex weight and containment test
  acc_t t3_raw;
  logic signed [31:0] t3;
  logic inside_ok;
  assign t3_raw = acc_t'(ONE_Q16) - acc_t'(t_r[0]) - acc_t'(t_r[1]) - acc_t'(t_r[2]);
  assign t3 = sat32(t3_raw);
  assign inside_ok = !t_r[0][31] && !t_r[1][31] && !t_r[2][31] && !t3[31];

  logic last_i;
  assign last_i = (i_r + CW'(1)) >= count_r;

  // query count clamp
  logic [CW-1:0] tc_ext, count_cl;
  assign tc_ext   = CW'(tcount_r);
  assign count_cl = (tc_ext > CW'(MAX_TETRA)) ? CW'(MAX_TETRA) : tc_ext;

  // sequencer next state
  logic pipe_empty;
  assign pipe_empty = !rd_v_r && !mul_v_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && f_func == FUNC_QUERY) begin
          state_nxt = (count_cl == '0) ? ST_OUT : ST_REF;
        end
      end
      ST_REF:   if (cnt_r == 4'd2) state_nxt = ST_MAT;
      ST_MAT:   if (cnt_r == 4'd8) state_nxt = ST_MWAIT;
      ST_MWAIT: if (pipe_empty) state_nxt = ST_CHK;
      ST_CHK: begin
        if (inside_ok) state_nxt = ST_IDS;
        else if (last_i) state_nxt = ST_OUT;
        else state_nxt = ST_REF;
      end
      ST_IDS:   if (cnt_r == 4'd3) state_nxt = ST_IWAIT;
      ST_IWAIT: if (!rd_v_r) state_nxt = ST_BLEND;
      ST_BLEND: if (cnt_r == 4'd3) state_nxt = ST_BWAIT;
      ST_BWAIT: if (pipe_empty) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) begin
          if (ck_r == 5'(SH_COEFS - 1)) state_nxt = ST_IDLE;
          else if (found_r) state_nxt = ST_BLEND;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tcount_r <= '0;
      rd_v_r   <= 1'b0;
      mul_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) tcount_r <= cfg_wr_data;
      rd_v_r  <= (state_r == ST_REF) || (state_r == ST_MAT) ||
                 (state_r == ST_IDS) || (state_r == ST_BLEND);
      mul_v_r <= rd_v_r && (rd_kind_r == RD_MAT || rd_kind_r == RD_COEF);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    if (rd_kind_r == RD_MAT) begin
      op_a = d_r[rd_sel_r];
      op_b = mat_rd;
    end else begin
      op_a = rd_zero_r ? 32'sd0 : coef_rd;
      op_b = w_r[rd_sel_r];
    end
  end

  assign acc_sum = (mul_first_r ? acc_t'(0) : acc_r) + acc_t'($signed(prod_r[63:16]));

  // datapath and counters
  always_ff @(posedge clk) begin
    // read tags
    rd_sel_r  <= (state_r == ST_MAT) ? mj_r : cnt_r[1:0];
    rd_k_r    <= mk_r;
    rd_zero_r <= cur_zero;
    unique case (state_r)
      ST_MAT:   rd_kind_r <= RD_MAT;
      ST_IDS:   rd_kind_r <= RD_IDS;
      ST_BLEND: rd_kind_r <= RD_COEF;
      default:  rd_kind_r <= RD_REF;
    endcase

    // returned data
    if (rd_v_r && rd_kind_r == RD_REF) begin
      d_r[rd_sel_r] <= sat32(acc_t'(pos_r[rd_sel_r]) - acc_t'($signed(ref_rd)));
    end
    if (rd_v_r && rd_kind_r == RD_IDS) ids_r[rd_sel_r] <= ids_rd;

    // multiply, then accumulate floored products
    prod_r      <= op_a * op_b;
    mul_first_r <= rd_sel_r == 2'd0;
    mul_last_r  <= (rd_kind_r == RD_MAT) ? (rd_sel_r == 2'd2) : (rd_sel_r == 2'd3);
    mul_mat_r   <= rd_kind_r == RD_MAT;
    mul_k_r     <= rd_k_r;
    if (mul_v_r) begin
      acc_r <= acc_sum;
      if (mul_last_r) begin
        if (mul_mat_r) t_r[mul_k_r] <= sat32(acc_sum);
        else val_r <= sat32(acc_sum);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        cnt_r <= '0;
        mj_r  <= '0;
        mk_r  <= '0;
        ck_r  <= '0;
        if (accept && f_func == FUNC_QUERY) begin
          pos_r[0] <= in_tdata[88:57];
          pos_r[1] <= in_tdata[120:89];
          pos_r[2] <= in_tdata[152:121];
          count_r  <= count_cl;
          i_r      <= '0;
          hit_r    <= '0;
          found_r  <= 1'b0;
          val_r    <= ONE_Q16;
          for (int n = 0; n < 4; n++) w_r[n] <= '0;
        end
      end
      ST_REF: cnt_r <= (cnt_r == 4'd2) ? 4'd0 : cnt_r + 4'd1;
      ST_MAT: begin
        cnt_r <= (cnt_r == 4'd8) ? 4'd0 : cnt_r + 4'd1;
        if (mj_r == 2'd2) begin
          mj_r <= '0;
          mk_r <= mk_r + 2'd1;
        end else begin
          mj_r <= mj_r + 2'd1;
        end
      end
      ST_CHK: begin
        mj_r <= '0;
        mk_r <= '0;
        cnt_r <= '0;
        if (inside_ok) begin
          found_r <= 1'b1;
          hit_r   <= i_r;
          for (int n = 0; n < 3; n++) w_r[n] <= t_r[n];
          w_r[3]  <= t3;
        end else begin
          i_r <= i_r + CW'(1);
        end
      end
      ST_IDS:   cnt_r <= (cnt_r == 4'd3) ? 4'd0 : cnt_r + 4'd1;
      ST_BLEND: cnt_r <= (cnt_r == 4'd3) ? 4'd0 : cnt_r + 4'd1;
      ST_OUT: begin
        if (out_tready && ck_r != 5'(SH_COEFS - 1)) ck_r <= ck_r + 5'd1;
      end
      default: ;
    endcase
  end

  // output word
  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = state_r == ST_OUT;
  assign out_tlast  = ck_r == 5'(SH_COEFS - 1);
  assign out_tuser  = found_r;
  assign out_tdata  = {3'b000, val_r, ck_r, w_r[3], w_r[2], w_r[1], w_r[0], hit_r[7:0]};

  // checks
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while a word is pending");
  a_notfound_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !found_r) |-> (val_r == ONE_Q16 && hit_r == '0))
    else $error("not-found word carries wrong value");
  a_found_weights: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && found_r) |-> (!w_r[0][31] && !w_r[1][31] && !w_r[2][31] && !w_r[3][31]))
    else $error("negative weight on a found query");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> state_r == ST_IDLE)
    else $error("query did not end after its last word");

endmodule

// ===== dv/tpl_checker.sv =====
// watches both streams of the tetrahedral probe interpolator, predicts every result word
// from its own copy of the tables and the tetra_count register, and counts mismatches
// depends on tpl_pkg for the func codes and table sizes
`timescale 1ns / 100ps

module tpl_checker
  import tpl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [8:0]   cfg_wr_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [175:0] out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic              found;
    logic [7:0]        idx;
    logic signed [31:0] wa;
    logic signed [31:0] wb;
    logic signed [31:0] wc;
    logic signed [31:0] wd;
    logic [4:0]        k;
    logic signed [31:0] val;
    logic              last;
  } blend_word_t;

  // shadow tables
  logic signed [31:0] mat_tab [0:MAX_TETRA_DEF*9-1];
  logic signed [31:0] ref_tab [0:MAX_TETRA_DEF*3-1];
  logic [7:0]         pid_tab [0:MAX_TETRA_DEF*4-1];
  logic signed [31:0] coef_tab [0:MAX_PROBES_DEF*SH_COEFS-1];
  logic [8:0]         tcount;
  blend_word_t        blend_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
    tcount = '0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, exp_v);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v) report_mismatch(what, got, exp_v);
  endtask

  // locate the containing tetrahedron and queue 27 blended words
  task automatic predict_blend(input logic signed [31:0] px, input logic signed [31:0] py,
                               input logic signed [31:0] pz);
    longint pos [3];
    longint dq [3];
    longint acc;
    logic signed [31:0] t [4];
    logic signed [31:0] w [4];
    bit hit;
    int idx, n, i, j, k;
    blend_word_t e;
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    n = (tcount > MAX_TETRA_DEF) ? MAX_TETRA_DEF : tcount;
    hit = 0;
    idx = 0;
    for (j = 0; j < 4; j++) w[j] = '0;
    for (i = 0; i < n && !hit; i++) begin
      for (j = 0; j < 3; j++) dq[j] = clamp32(pos[j] - longint'(ref_tab[i*3+j]));
      for (k = 0; k < 3; k++) begin
        acc = 0;
        for (j = 0; j < 3; j++) acc += (dq[j] * longint'(mat_tab[i*9+j*3+k])) >>> 16;
        t[k] = 32'(clamp32(acc));
      end
      t[3] = 32'(clamp32(64'sd65536 - longint'(t[0]) - longint'(t[1]) - longint'(t[2])));
      if (t[0] >= 0 && t[1] >= 0 && t[2] >= 0 && t[3] >= 0) begin
        hit = 1;
        idx = i;
        w = t;
      end
    end
    for (k = 0; k < SH_COEFS; k++) begin
      e.found = hit;
      e.idx = hit ? 8'(idx) : 8'd0;
      e.wa = w[0];
      e.wb = w[1];
      e.wc = w[2];
      e.wd = w[3];
      e.k = 5'(k);
      e.last = (k == SH_COEFS - 1);
      if (hit) begin
        acc = 0;
        for (j = 0; j < 4; j++)
          acc += (longint'(coef_tab[int'(pid_tab[idx*4+j])*SH_COEFS+k]) *
                  longint'(w[j])) >>> 16;
        e.val = 32'(clamp32(acc));
      end else begin
        e.val = ONE_Q16;
      end
      blend_q = {blend_q, e};
    end
  endtask

  always @(posedge clk) begin
    blend_word_t e;
    logic [7:0]  tslot, pslot;
    logic [3:0]  tword;
    logic [4:0]  cslot;
    logic signed [31:0] lv;
    if (!rst_n) begin
      tcount = '0;
      blend_q.delete();
    end else begin
      if (cfg_wr_en) tcount = cfg_wr_data;
      // input side: update tables or predict a query
      if (in_tvalid && in_tready) begin
        tslot = in_tdata[7:0];
        tword = in_tdata[11:8];
        pslot = in_tdata[19:12];
        cslot = in_tdata[24:20];
        lv    = in_tdata[56:25];
        case (in_tuser)
          FUNC_LOAD_TETRA: begin
            if (tword < 9) mat_tab[tslot*9+tword] = lv;
            else if (tword < 12) ref_tab[tslot*3+tword-9] = lv;
            else pid_tab[tslot*4+tword-12] = lv[7:0];
          end
          FUNC_LOAD_PROBE: begin
            if (cslot < SH_COEFS) coef_tab[pslot*SH_COEFS+cslot] = lv;
          end
          FUNC_QUERY: predict_blend(in_tdata[88:57], in_tdata[120:89], in_tdata[152:121]);
          default: ;
        endcase
      end
      // output side: compare against the oldest expected word
      if (out_tvalid && out_tready) begin
        if (blend_q.size() == 0) begin
          report_mismatch("unexpected word", out_tdata[172:141], '0);
        end else begin
          e = blend_q.pop_front();
          check_field("found", 32'(out_tuser[0]), 32'(e.found));
          check_field("tetra_index", 32'(out_tdata[7:0]), 32'(e.idx));
          check_field("weight_a", out_tdata[39:8], e.wa);
          check_field("weight_b", out_tdata[71:40], e.wb);
          check_field("weight_c", out_tdata[103:72], e.wc);
          check_field("weight_d", out_tdata[135:104], e.wd);
          check_field("coef_index", 32'(out_tdata[140:136]), 32'(e.k));
          check_field("coef_value", out_tdata[172:141], e.val);
          check_field("last", 32'(out_tlast), 32'(e.last));
        end
      end
    end
    pending = blend_q.size();
  end

endmodule

// ===== dv/tb_tetra_probe_locate_interpolate.sv =====
// stimulus and verdict for the tetrahedral probe interpolator: table loads, queries,
// tetra_count phases and random idling; checking is done in tpl_checker
// depends on tpl_pkg, tpl_checker and the rtl top level
`timescale 1ns / 100ps

module tb_tetra_probe_locate_interpolate;
  import tpl_pkg::*;

  // tetrahedra filled at start; tetra_count stays within them except in the phase that sets it to 511
  localparam int NT = 4;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [8:0]   cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // tetra_slot, tetra_word, probe_slot, coef_slot, load_value, pos_x, pos_y, pos_z
  logic [159:0] in_tdata = '0;
  // func
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // tetra_index, weight_a, weight_b, weight_c, weight_d, coef_index, coef_value
  logic [175:0] out_tdata;
  // found
  logic [0:0]   out_tuser;
  logic         out_tlast;

  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_stall = 0;
  int long_hold = 0;
  int cur_count = 0;
  logic signed [31:0] ref_shadow [0:767];
  int cfg_vals [8] = '{1, 4, 2, 0, 4, 3, 4, 1};

  tetra_probe_locate_interpolate u_dut (.*);

  tpl_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off while long_hold is set
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_tready <= 1'b0;
        long_hold--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  function automatic logic [159:0] pack_word(input logic [7:0] tslot, input logic [3:0] tword,
                                             input logic [7:0] pslot, input logic [4:0] cslot,
                                             input logic [31:0] lv, input logic [31:0] px,
                                             input logic [31:0] py, input logic [31:0] pz);
    return {7'd0, pz, py, px, lv, cslot, pslot, tword, tslot};
  endfunction

  task automatic send_word(input logic [1:0] f, input logic [159:0] d);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_tetra(input int slot, input int word, input logic [31:0] v);
    send_word(FUNC_LOAD_TETRA, pack_word(8'(slot), 4'(word), 8'($urandom), 5'($urandom), v,
                                         $urandom, $urandom, $urandom));
    if (word >= 9 && word < 12) ref_shadow[slot*3+word-9] = v;
  endtask

  task automatic load_coef(input int slot, input int cs, input logic [31:0] v);
    send_word(FUNC_LOAD_PROBE, pack_word(8'($urandom), 4'($urandom), 8'(slot), 5'(cs), v,
                                         $urandom, $urandom, $urandom));
  endtask

  task automatic query(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
    send_word(FUNC_QUERY, pack_word(8'($urandom), 4'($urandom), 8'($urandom), 5'($urandom),
                                    $urandom, px, py, pz));
  endtask

  // query a point just inside the simplex of tetrahedron t
  task automatic query_near(input int t);
    int ox, oy, oz;
    ox = $urandom_range(0, 30000);
    oy = $urandom_range(0, 30000);
    oz = $urandom_range(0, 5000);
    query(ref_shadow[t*3] + ox, ref_shadow[t*3+1] + oy, ref_shadow[t*3+2] + oz);
  endtask

  // probe ids always point at fully written probes 0, 1 or 255
  function automatic logic [31:0] probe_id_word();
    int id;
    id = $urandom_range(0, 2);
    if (id == 2) id = 255;
    return ($urandom & 32'hffffff00) | 32'(id);
  endfunction

  task automatic write_count(input int v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 9'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_count = v;
  endtask

  // stop sending and let every expected word come out, then let loads settle
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_items(input int n);
    int done, r, t, w, lim;
    done = 0;
    lim = (cur_count > 256) ? 256 : cur_count;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 30) begin
        query_near((lim == 0) ? 0 : $urandom_range(0, lim - 1));
      end else if (r < 40) begin
        query($urandom, $urandom, $urandom);
      end else if (r < 65) begin
        t = $urandom_range(0, 255);
        w = $urandom_range(0, 15);
        if (w < 9) begin
          if ($urandom_range(1)) load_tetra(t, w, $urandom);
          else load_tetra(t, w, (w % 4 == 0) ? 32'(65536 * $urandom_range(1, 4)) : 32'd0);
        end else if (w < 12) begin
          load_tetra(t, w, $urandom_range(1) ? $urandom : 32'(t << 18));
        end else begin
          load_tetra(t, w, probe_id_word());
        end
      end else if (r < 90) begin
        load_coef($urandom_range(0, 255), $urandom_range(0, 26), $urandom);
      end else if (r < 95) begin
        // coefficient number out of range: ignored
        load_coef($urandom_range(0, 255), $urandom_range(27, 31), $urandom);
        done--;
      end else begin
        // unused func: ignored
        send_word(FUNC_UNUSED, {$urandom, $urandom, $urandom, $urandom, $urandom});
        done--;
      end
      done++;
    end
  endtask

  initial begin
    int i, j, ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: not-found answers
    query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    query(32'h80000000, 32'h80000000, 32'h80000000);
    send_word(FUNC_UNUSED, '1);
    load_coef(0, 31, 32'h12345678);
    drain();

    // fill the searched tetrahedra and the probes they may use
    for (i = 0; i < NT; i++) begin
      for (j = 0; j < 9; j++) load_tetra(i, j, (j % 4 == 0) ? 32'd65536 : 32'd0);
      load_tetra(i, 9, 32'(i << 18));
      load_tetra(i, 10, -32'(i << 17));
      load_tetra(i, 11, 32'd0);
      for (j = 12; j < 16; j++) load_tetra(i, j, probe_id_word());
    end
    load_tetra(0, 15, 32'd255);
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 27; j++)
        load_coef((i == 2) ? 255 : i, j,
                  (j == 0) ? 32'h7fffffff : (j == 1) ? 32'h80000000 : $urandom);
    end
    drain();

    // one tetrahedron: boundary points
    write_count(1);
    query(0, 0, 0);
    query(32'd65536, 0, 0);
    query(0, 0, 32'd65536);
    query(-32'd1, 0, 0);
    query(32'd65536, 32'd1, 0);
    query(32'd32768, 32'd16384, 32'd16384);
    query(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    drain();

    // count above the table size: a hit in the first tetrahedron ends the scan
    write_count(511);
    query_near(0);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      write_count(cfg_vals[ph]);
      if (ph == 2) begin
        // long receiver hold-off while queries keep coming
        long_hold = 600;
        for (i = 0; i < 6; i++) query_near(0);
      end
      random_items(10);
      drain();
    end

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tpl_pkg.sv
rtl/tpl_ram.sv
rtl/tetra_probe_locate_interpolate.sv
dv/tpl_checker.sv
dv/tb_tetra_probe_locate_interpolate.sv
